[rtl/core/key_partition_owner_lookup_core_assert.svh]
// Assertion macros shared by the partition owner lookup RTL.
// Each macro clocks on the rising edge and is disabled while reset is high.
`ifndef KEY_PARTITION_OWNER_LOOKUP_CORE_ASSERT_SVH
`define KEY_PARTITION_OWNER_LOOKUP_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPOL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/kpol_pkg.sv]
// Shared types and constants of the partition owner lookup core.
// No dependencies; all files of the block but kpol_ram and the assertion header use it.
package kpol_pkg;

  localparam int MAX_PARTS_DEF = 1024;
  localparam int PART_W        = 10;
  localparam int CNT_W         = 11;
  localparam int OWNER_W       = 64;
  localparam int HASH_W        = 32;
  localparam int FOLD_SHIFT    = 16;
  localparam int MAX_TABLE     = 1 << PART_W;
  localparam int ROW_BITS      = 32;
  localparam int ROW_SH        = 5;

  typedef enum logic [1:0] {
    CMD_ASSIGN = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_KEY    = 2'd2,
    CMD_PART   = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLR,
    ST_A_RD,
    ST_A_WR,
    ST_DIV,
    ST_RD,
    ST_RDW,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    IDX_PART,
    IDX_FOLD,
    IDX_DIV
  } idx_sel_t;

  typedef enum logic [2:0] {
    RES_ASSIGN,
    RES_CLEAR,
    RES_READ,
    RES_ERR_PART,
    RES_ERR_KEY
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     clr_table;
    logic     sweep_step;
    logic     div_start;
    logic     idx_load;
    idx_sel_t idx_sel;
    logic     rd_en;
    logic     asg_wr;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } dp_ctl_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      over_cap;
    logic      part_oor;
    logic      count_zero;
    logic      count_pow2;
    logic      div_done;
    logic      sweep_last;
  } dp_stat_t;

endpackage

[rtl/core/kpol_if.sv]
// Request and response channel interfaces of the partition owner lookup core.
// Depends on kpol_pkg for the field widths.
interface kpol_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic [kpol_pkg::PART_W-1:0]         part_in;
  logic [kpol_pkg::OWNER_W-1:0]        owner_in_hi;
  logic [kpol_pkg::OWNER_W-1:0]        owner_in_lo;
  logic signed [kpol_pkg::HASH_W-1:0]  key_hash;

  modport source (output valid, cmd, part_in, owner_in_hi, owner_in_lo, key_hash,
                  input ready);
  modport sink (input valid, cmd, part_in, owner_in_hi, owner_in_lo, key_hash,
                output ready);
endinterface

interface kpol_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [kpol_pkg::PART_W-1:0]   part_out;
  logic [kpol_pkg::OWNER_W-1:0]  owner_out_hi;
  logic [kpol_pkg::OWNER_W-1:0]  owner_out_lo;
  logic [kpol_pkg::CNT_W-1:0]    part_count;

  modport source (output valid, status, part_out, owner_out_hi, owner_out_lo, part_count,
                  input ready);
  modport sink (input valid, status, part_out, owner_out_hi, owner_out_lo, part_count,
                output ready);
endinterface

[rtl/core/kpol_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kpol_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/kpol_div.sv]
// Radix-2 restoring remainder unit: magnitude of the hash modulo the partition count.
// One quotient bit per cycle; depends on kpol_pkg for widths.
module kpol_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [kpol_pkg::HASH_W-1:0]   dividend,
  input  logic [kpol_pkg::CNT_W-1:0]    divisor,
  output logic [kpol_pkg::CNT_W-1:0]    rem,
  output logic                          done
);
  import kpol_pkg::*;

  localparam int SW = $clog2(HASH_W);

  logic [HASH_W-1:0] sh;
  logic [SW-1:0]     step;
  logic              busy;
  logic [CNT_W-1:0]  rem_sh;
  logic [CNT_W:0]    diff;

  // rem stays below divisor (at most 1024), so its top bit is free for the shift
  assign rem_sh = {rem[CNT_W-2:0], sh[HASH_W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      sh   <= dividend;
      rem  <= '0;
      step <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= diff[CNT_W] ? rem_sh : diff[CNT_W-1:0];
      sh   <= {sh[HASH_W-2:0], 1'b0};
      step <= step + SW'(1);
      if (step == SW'(HASH_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/kpol_dp.sv]
// Datapath: item registers, partition count, owner and written-bit memories,
// partition computation, result and output registers. Depends on kpol_pkg,
// kpol_ram and kpol_div.
module kpol_dp #(
  parameter int MAX_PARTS = kpol_pkg::MAX_PARTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  kpol_pkg::dp_ctl_t                   ctl,
  output kpol_pkg::dp_stat_t                  stat,
  input  logic [1:0]                          cmd,
  input  logic [kpol_pkg::PART_W-1:0]         part_in,
  input  logic [kpol_pkg::OWNER_W-1:0]        owner_in_hi,
  input  logic [kpol_pkg::OWNER_W-1:0]        owner_in_lo,
  input  logic signed [kpol_pkg::HASH_W-1:0]  key_hash,
  output logic                                status,
  output logic [kpol_pkg::PART_W-1:0]         part_out,
  output logic [kpol_pkg::OWNER_W-1:0]        owner_out_hi,
  output logic [kpol_pkg::OWNER_W-1:0]        owner_out_lo,
  output logic [kpol_pkg::CNT_W-1:0]          part_count
);
  import kpol_pkg::*;

  localparam int DEPTH = (MAX_PARTS < MAX_TABLE) ? MAX_PARTS : MAX_TABLE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROWS  = (DEPTH + ROW_BITS - 1) / ROW_BITS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  cmd_code_t           cmd_r;
  logic [PART_W-1:0]   part_r;
  logic [OWNER_W-1:0]  ohi_r;
  logic [OWNER_W-1:0]  olo_r;
  logic [HASH_W-1:0]   hash_r;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    part_plus;
  logic [RW-1:0]       sweep_cnt;
  logic [PART_W-1:0]   idx;
  logic [HASH_W-1:0]   mag;
  logic [HASH_W-1:0]   folded;
  logic [CNT_W-1:0]    div_rem;
  logic                div_done;

  logic                res_status;
  logic [PART_W-1:0]   res_part;
  logic [OWNER_W-1:0]  res_hi;
  logic [OWNER_W-1:0]  res_lo;

  logic [OWNER_W-1:0]  hi_q;
  logic [OWNER_W-1:0]  lo_q;
  logic [ROW_BITS-1:0] row_q;
  logic [RW-1:0]       row_addr;
  logic [ROW_SH-1:0]   col;
  logic                wr_we;
  logic [RW-1:0]       wr_addr;
  logic [ROW_BITS-1:0] wr_data;

  assign cnt_m1    = count - CNT_W'(1);
  assign part_plus = CNT_W'(part_r) + CNT_W'(1);
  assign mag       = hash_r[HASH_W-1] ? (~hash_r + HASH_W'(1)) : hash_r;
  assign folded    = hash_r ^ (hash_r >> FOLD_SHIFT);
  assign row_addr  = RW'(idx >> ROW_SH);
  assign col       = idx[ROW_SH-1:0];

  always_comb begin
    stat.cmd        = cmd_r;
    stat.over_cap   = 32'(part_r) >= 32'(MAX_PARTS);
    stat.part_oor   = CNT_W'(part_r) >= count;
    stat.count_zero = count == '0;
    stat.count_pow2 = (count & cnt_m1) == '0;
    stat.div_done   = div_done;
    stat.sweep_last = sweep_cnt == RW'(ROWS - 1);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r  <= cmd_code_t'(cmd);
      part_r <= part_in;
      ohi_r  <= owner_in_hi;
      olo_r  <= owner_in_lo;
      hash_r <= key_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sweep_cnt <= '0;
    end else begin
      if (ctl.clr_table) begin
        count     <= '0;
        sweep_cnt <= '0;
      end else begin
        if (ctl.asg_wr && (part_plus > count)) begin
          count <= part_plus;
        end
        if (ctl.sweep_step) begin
          sweep_cnt <= sweep_cnt + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.idx_load) begin
      case (ctl.idx_sel)
        IDX_FOLD: idx <= folded[PART_W-1:0] & cnt_m1[PART_W-1:0];
        IDX_DIV:  idx <= div_rem[PART_W-1:0];
        default:  idx <= part_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      case (ctl.res_sel)
        RES_ASSIGN: begin
          res_status <= 1'b0;
          res_part   <= part_r;
          res_hi     <= ohi_r;
          res_lo     <= olo_r;
        end
        RES_READ: begin
          res_status <= 1'b0;
          res_part   <= idx;
          res_hi     <= row_q[col] ? hi_q : '0;
          res_lo     <= row_q[col] ? lo_q : '0;
        end
        RES_ERR_PART: begin
          res_status <= 1'b1;
          res_part   <= part_r;
          res_hi     <= '0;
          res_lo     <= '0;
        end
        RES_ERR_KEY: begin
          res_status <= 1'b1;
          res_part   <= '0;
          res_hi     <= '0;
          res_lo     <= '0;
        end
        default: begin
          res_status <= 1'b0;
          res_part   <= '0;
          res_hi     <= '0;
          res_lo     <= '0;
        end
      endcase
    end
  end

  // part_count is sampled here so it reflects the item's own update
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status       <= res_status;
      part_out     <= res_part;
      owner_out_hi <= res_hi;
      owner_out_lo <= res_lo;
      part_count   <= count;
    end
  end

  // Written bits: sweep zero rows, or set one bit of the row read beforehand
  always_comb begin
    wr_we   = ctl.sweep_step || ctl.asg_wr;
    wr_addr = ctl.sweep_step ? sweep_cnt : row_addr;
    wr_data = ctl.sweep_step ? '0 : (row_q | (ROW_BITS'(1) << col));
  end

  kpol_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (mag),
    .divisor  (count),
    .rem      (div_rem),
    .done     (div_done)
  );

  kpol_ram #(.W(OWNER_W), .DEPTH(DEPTH)) u_hi_ram (
    .clk   (clk),
    .we    (ctl.asg_wr),
    .waddr (idx[AW-1:0]),
    .wdata (ohi_r),
    .re    (ctl.rd_en),
    .raddr (idx[AW-1:0]),
    .rdata (hi_q)
  );

  kpol_ram #(.W(OWNER_W), .DEPTH(DEPTH)) u_lo_ram (
    .clk   (clk),
    .we    (ctl.asg_wr),
    .waddr (idx[AW-1:0]),
    .wdata (olo_r),
    .re    (ctl.rd_en),
    .raddr (idx[AW-1:0]),
    .rdata (lo_q)
  );

  kpol_ram #(.W(ROW_BITS), .DEPTH(ROWS)) u_wr_ram (
    .clk   (clk),
    .we    (wr_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (row_addr),
    .rdata (row_q)
  );

endmodule

[rtl/core/kpol_ctrl.sv]
// Controller state machine of the partition owner lookup core.
// Sequences the datapath through commands and owns the response valid flag.
// Depends on kpol_pkg.
module kpol_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  input  kpol_pkg::dp_stat_t  stat,
  output kpol_pkg::dp_ctl_t   ctl
);
  import kpol_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (stat.sweep_last) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (stat.cmd)
          CMD_ASSIGN: state_next = stat.over_cap ? ST_DONE : ST_A_RD;
          CMD_CLEAR:  state_next = ST_CLR;
          CMD_KEY: begin
            if (stat.count_zero) begin
              state_next = ST_DONE;
            end else if (stat.count_pow2) begin
              state_next = ST_RD;
            end else begin
              state_next = ST_DIV;
            end
          end
          default:    state_next = stat.part_oor ? ST_DONE : ST_RD;
        endcase
      end
      ST_CLR:    if (stat.sweep_last) state_next = ST_DONE;
      ST_A_RD:   state_next = ST_A_WR;
      ST_A_WR:   state_next = ST_DONE;
      ST_DIV:    if (stat.div_done) state_next = ST_RD;
      ST_RD:     state_next = ST_RDW;
      ST_RDW:    state_next = ST_DONE;
      ST_DONE:   if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ctl       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_INIT: ctl.sweep_step = 1'b1;
      ST_IDLE: begin
        req_ready   = 1'b1;
        ctl.load_in = req_valid;
      end
      ST_DECODE: begin
        unique case (stat.cmd)
          CMD_ASSIGN: begin
            ctl.idx_load = 1'b1;
            ctl.idx_sel  = IDX_PART;
            ctl.res_load = stat.over_cap;
            ctl.res_sel  = RES_ERR_PART;
          end
          CMD_CLEAR: ctl.clr_table = 1'b1;
          CMD_KEY: begin
            if (stat.count_zero) begin
              ctl.res_load = 1'b1;
              ctl.res_sel  = RES_ERR_KEY;
            end else if (stat.count_pow2) begin
              ctl.idx_load = 1'b1;
              ctl.idx_sel  = IDX_FOLD;
            end else begin
              ctl.div_start = 1'b1;
            end
          end
          default: begin
            ctl.idx_load = 1'b1;
            ctl.idx_sel  = IDX_PART;
            ctl.res_load = stat.part_oor;
            ctl.res_sel  = RES_ERR_PART;
          end
        endcase
      end
      ST_CLR: begin
        ctl.sweep_step = 1'b1;
        ctl.res_load   = stat.sweep_last;
        ctl.res_sel    = RES_CLEAR;
      end
      ST_A_RD: ctl.rd_en = 1'b1;
      ST_A_WR: begin
        ctl.asg_wr   = 1'b1;
        ctl.res_load = 1'b1;
        ctl.res_sel  = RES_ASSIGN;
      end
      ST_DIV: begin
        ctl.idx_load = stat.div_done;
        ctl.idx_sel  = IDX_DIV;
      end
      ST_RD: ctl.rd_en = 1'b1;
      ST_RDW: begin
        ctl.res_load = 1'b1;
        ctl.res_sel  = RES_READ;
      end
      ST_DONE: ctl.out_load = slot_free;
      default: ctl = '0;
    endcase
  end

  // Hold the response until taken; a new load replaces a beat leaving this cycle
  always_comb begin
    if (ctl.out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[rtl/core/key_partition_owner_lookup_core.sv]
// Partition owner lookup core: maps partitions to 128-bit owner ids.
// Request channel req carries one command per beat: assign an owner to a
// partition, clear the table, look up the owner of a key hash, or look up
// the owner of a partition index. Every request gives exactly one beat on
// the response channel rsp with status, partition, owner and the count.
// One request is worked on at a time. A key lookup runs the 32-step
// remainder unit (one quotient bit per cycle) unless the count is a power
// of two. The next request is taken the cycle after the response is
// loaded into the output register. After reset the written-bit memory is
// swept, one 32-bit row per cycle; req.ready stays low during the sweep.
// A clear runs the same sweep. If rsp stalls, the finished beat waits in
// the output register and one more request may be taken and worked on;
// its result then waits until the output register is free.
`include "key_partition_owner_lookup_core_assert.svh"

module key_partition_owner_lookup_core #(
  parameter int MAX_PARTS = kpol_pkg::MAX_PARTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  kpol_req_if.sink   req,
  kpol_rsp_if.source rsp
);
  import kpol_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  kpol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .stat      (stat),
    .ctl       (ctl)
  );

  kpol_dp #(.MAX_PARTS(MAX_PARTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cmd          (req.cmd),
    .part_in      (req.part_in),
    .owner_in_hi  (req.owner_in_hi),
    .owner_in_lo  (req.owner_in_lo),
    .key_hash     (req.key_hash),
    .status       (rsp.status),
    .part_out     (rsp.part_out),
    .owner_out_hi (rsp.owner_out_hi),
    .owner_out_lo (rsp.owner_out_lo),
    .part_count   (rsp.part_count)
  );

  `KPOL_ASSERT_NEXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready, "request taken while busy")
  `KPOL_ASSERT_NOW(a_no_overwrite, clk, rst, ctl.out_load, !rsp.valid || rsp.ready, "response overwritten")
  `KPOL_ASSERT_NEXT(a_div_restart, clk, rst, ctl.div_start, !stat.div_done, "remainder done too early")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for key_partition_owner_lookup_core: random and directed command beats,
// checked against a table shadow kept in a small scoreboard class.
// Depends on kpol_pkg, kpol_if and the core RTL.
module tb_top;
  import kpol_pkg::*;

  typedef struct packed {
    logic               status;
    logic [PART_W-1:0]  part;
    logic [OWNER_W-1:0] hi;
    logic [OWNER_W-1:0] lo;
    logic [CNT_W-1:0]   count;
  } owner_reply_t;

  class owner_table_check;
    logic [OWNER_W-1:0] hi_mem [MAX_TABLE];
    logic [OWNER_W-1:0] lo_mem [MAX_TABLE];
    bit                 written [MAX_TABLE];
    int unsigned        total;
    owner_reply_t       owed [$];
    int unsigned        bad_count;

    function new();
      total = 0;
      bad_count = 0;
    endfunction

    function logic [PART_W-1:0] key_partition(logic [HASH_W-1:0] h);
      logic [31:0] cnt;
      logic [31:0] mag;
      cnt = total;
      if ((cnt & (cnt - 1)) == 0)
        return PART_W'((h ^ (h >> FOLD_SHIFT)) & (cnt - 1));
      // the most negative hash wraps to 2^31 as unsigned
      mag = h[31] ? (32'd0 - h) : h;
      return PART_W'(mag % cnt);
    endfunction

    function void take_request(cmd_code_t c, logic [PART_W-1:0] p, logic [OWNER_W-1:0] hi,
                               logic [OWNER_W-1:0] lo, logic [HASH_W-1:0] h);
      owner_reply_t r;
      logic [PART_W-1:0] idx;
      r = '0;
      case (c)
        CMD_ASSIGN: begin
          r.part = p;
          hi_mem[p] = hi;
          lo_mem[p] = lo;
          written[p] = 1'b1;
          if (p + 1 > total) total = p + 1;
          r.hi = hi;
          r.lo = lo;
        end
        CMD_CLEAR: begin
          foreach (written[i]) written[i] = 1'b0;
          total = 0;
        end
        CMD_KEY: begin
          if (total == 0) begin
            r.status = 1'b1;
          end else begin
            idx = key_partition(h);
            r.part = idx;
            if (written[idx]) begin
              r.hi = hi_mem[idx];
              r.lo = lo_mem[idx];
            end
          end
        end
        default: begin
          r.part = p;
          if (p >= total) begin
            r.status = 1'b1;
          end else if (written[p]) begin
            r.hi = hi_mem[p];
            r.lo = lo_mem[p];
          end
        end
      endcase
      r.count = CNT_W'(total);
      owed.push_back(r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      bad_count++;
      if (bad_count <= 10)
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    endfunction

    function void check_reply(owner_reply_t got);
      owner_reply_t want;
      if (owed.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t response beat with nothing outstanding: %p", $realtime, got);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) flag("status", 64'(want.status), 64'(got.status));
      if (got.part !== want.part) flag("part_out", 64'(want.part), 64'(got.part));
      if (got.hi !== want.hi) flag("owner_out_hi", want.hi, got.hi);
      if (got.lo !== want.lo) flag("owner_out_lo", want.lo, got.lo);
      if (got.count !== want.count) flag("part_count", 64'(want.count), 64'(got.count));
    endfunction
  endclass

  logic clk;
  logic rst;
  kpol_req_if req_ch ();
  kpol_rsp_if rsp_ch ();

  owner_table_check sb = new();
  int unsigned beats_sent = 0;
  owner_reply_t seen;

  key_partition_owner_lookup_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OWNER_W-1:0] draw_owner();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [HASH_W-1:0] draw_hash();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return $urandom_range(0, 2000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly inside the session's table, sometimes just past it or anywhere.
  function automatic logic [PART_W-1:0] part_around(int unsigned n);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 9);
    if (r == 0) return PART_W'($urandom_range(0, MAX_TABLE - 1));
    if (r == 1) begin
      v = n + $urandom_range(0, 3);
      return PART_W'((v > MAX_TABLE - 1) ? MAX_TABLE - 1 : v);
    end
    return PART_W'($urandom_range(0, n - 1));
  endfunction

  task automatic issue_command(cmd_code_t c, logic [PART_W-1:0] p, logic [OWNER_W-1:0] hi,
                               logic [OWNER_W-1:0] lo, logic [HASH_W-1:0] h);
    int unsigned gap;
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.part_in <= p;
    req_ch.owner_in_hi <= hi;
    req_ch.owner_in_lo <= lo;
    req_ch.key_hash <= h;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.take_request(c, p, hi, lo, h);
    beats_sent++;
    gap = ((beats_sent / 64) % 5 == 0) ? 0 : draw_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_session();
    int unsigned n;
    int unsigned k;
    int unsigned body;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) n = $urandom_range(1, 16);
    else if (r < 8) n = 1 << $urandom_range(0, 7);
    else if (r < 9) n = $urandom_range(17, 300);
    else n = $urandom_range(0, 1) ? MAX_TABLE : $urandom_range(513, MAX_TABLE - 1);
    issue_command(CMD_CLEAR, PART_W'($urandom), draw_owner(), draw_owner(), $urandom);
    issue_command(CMD_ASSIGN, PART_W'(n - 1), draw_owner(), draw_owner(), $urandom);
    k = $urandom_range(0, (n - 1 < 12) ? n - 1 : 12);
    repeat (k) issue_command(CMD_ASSIGN, PART_W'($urandom_range(0, n - 1)), draw_owner(),
                             draw_owner(), $urandom);
    body = $urandom_range(20, 60);
    repeat (body) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        issue_command(CMD_KEY, PART_W'($urandom), draw_owner(), draw_owner(), draw_hash());
      else if (r < 70)
        issue_command(CMD_PART, part_around(n), draw_owner(), draw_owner(), $urandom);
      else if (r < 95)
        issue_command(CMD_ASSIGN, part_around(n), draw_owner(), draw_owner(), $urandom);
      else
        issue_command(CMD_CLEAR, PART_W'($urandom), draw_owner(), draw_owner(), $urandom);
    end
  endtask

  // Response side: random stalls, quiet windows, and one long hold-off.
  initial begin
    int unsigned stall_left;
    int unsigned cyc;
    bit held;
    stall_left = 0;
    cyc = 0;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && beats_sent >= 300) begin
        held = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && (cyc / 512) % 4 != 0 && $urandom_range(0, 3) == 0) begin
        stall_left = draw_gap();
      end
      rsp_ch.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      seen.status = rsp_ch.status;
      seen.part = rsp_ch.part_out;
      seen.hi = rsp_ch.owner_out_hi;
      seen.lo = rsp_ch.owner_out_lo;
      seen.count = rsp_ch.part_count;
      sb.check_reply(seen);
    end
  end

  initial begin
    int unsigned directed;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CMD_ASSIGN;
    req_ch.part_in <= '0;
    req_ch.owner_in_hi <= '0;
    req_ch.owner_in_lo <= '0;
    req_ch.key_hash <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table errors
    issue_command(CMD_KEY, 0, 0, 0, $urandom);
    issue_command(CMD_PART, 0, 0, 0, 0);
    // power-of-two count, extreme owners and hashes
    issue_command(CMD_ASSIGN, 0, '1, '0, 0);
    issue_command(CMD_ASSIGN, 1, draw_owner(), draw_owner(), 0);
    issue_command(CMD_ASSIGN, 2, draw_owner(), draw_owner(), 0);
    issue_command(CMD_ASSIGN, 3, '0, '1, 0);
    issue_command(CMD_KEY, 0, 0, 0, 32'h7fff_ffff);
    issue_command(CMD_KEY, 0, 0, 0, 32'h8000_0000);
    issue_command(CMD_PART, 3, 0, 0, 0);
    issue_command(CMD_PART, 4, 0, 0, 0);
    issue_command(CMD_PART, PART_W'(MAX_TABLE - 1), 0, 0, 0);
    issue_command(CMD_CLEAR, 0, 0, 0, 0);
    issue_command(CMD_PART, 0, 0, 0, 0);
    // count of five leaves entries below it unassigned
    issue_command(CMD_ASSIGN, 4, draw_owner(), draw_owner(), 0);
    issue_command(CMD_PART, 1, 0, 0, 0);
    issue_command(CMD_KEY, 0, 0, 0, 32'h8000_0000);
    issue_command(CMD_KEY, 0, 0, 0, 32'hffff_ffff);
    issue_command(CMD_KEY, 0, 0, 0, 32'h7fff_ffff);
    issue_command(CMD_KEY, 0, 0, 0, 32'h0);
    // full table size through the top index
    issue_command(CMD_ASSIGN, PART_W'(MAX_TABLE - 1), '1, '1, 0);
    issue_command(CMD_KEY, 0, 0, 0, 32'h0000_03ff);
    issue_command(CMD_PART, PART_W'(MAX_TABLE - 1), 0, 0, 0);
    issue_command(CMD_CLEAR, '1, '1, '1, '1);
    directed = beats_sent;

    while (beats_sent - directed < 850) run_session();
    req_ch.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.bad_count == 0 && sb.owed.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[key_partition_owner_lookup_core.f]
+incdir+rtl/core
rtl/core/kpol_pkg.sv
rtl/core/kpol_if.sv
rtl/core/kpol_ram.sv
rtl/core/kpol_div.sv
rtl/core/kpol_dp.sv
rtl/core/kpol_ctrl.sv
rtl/core/key_partition_owner_lookup_core.sv
sim/tb_top.sv
